// ===== sv/wts_pkg.sv =====
// Shared types, constants and waveform tables of the wavetable tone synthesizer.
`timescale 1ns / 1ps
package wts_pkg;

   localparam int DIV_WIDTH = 32;

   localparam logic [2:0] SEL_MAIN  = 3'd0;
   localparam logic [2:0] SEL_PITCH = 3'd1;
   localparam logic [2:0] SEL_VOL   = 3'd2;
   localparam logic [2:0] SEL_D     = 3'd3;
   localparam logic [2:0] SEL_ENV   = 3'd4;

   localparam logic [2:0] MODEL_SINE   = 3'd0;
   localparam logic [2:0] MODEL_TRI    = 3'd1;
   localparam logic [2:0] MODEL_SAWUP  = 3'd2;
   localparam logic [2:0] MODEL_SAWDN  = 3'd3;
   localparam logic [2:0] MODEL_SQUARE = 3'd4;
   localparam logic [2:0] MODEL_NOISE  = 3'd5;

   localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
   localparam logic [2:0] REG_MAIN_OSC     = 3'd1;
   localparam logic [2:0] REG_PITCH_OSC    = 3'd2;
   localparam logic [2:0] REG_VOLUME_OSC   = 3'd3;
   localparam logic [2:0] REG_ENVELOPE     = 3'd4;

   typedef logic [7:0] rom_type [256];
   typedef logic [5:0] qsine_type [65];

   localparam qsine_type QSINE = '{
      6'd0, 6'd1, 6'd3, 6'd4, 6'd6, 6'd7, 6'd9, 6'd10, 6'd12, 6'd14, 6'd15, 6'd17,
      6'd18, 6'd20, 6'd21, 6'd23, 6'd24, 6'd25, 6'd27, 6'd28, 6'd30, 6'd31, 6'd32,
      6'd34, 6'd35, 6'd36, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd44, 6'd45, 6'd46,
      6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd54, 6'd55, 6'd56,
      6'd57, 6'd57, 6'd58, 6'd59, 6'd59, 6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62,
      6'd62, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63};

   // Noise entries: bits 23:16 of a linear congruential sequence, halved toward zero.
   function automatic rom_type build_noise();
      rom_type rom;
      logic [31:0] seed;
      logic signed [7:0] r;
      seed = 32'd0;
      for (int i = 0; i < 256; i++) begin
         seed = seed * 32'd214013 + 32'd2531011;
         r = $signed(seed[23:16]);
         if (r < 0) begin
            rom[i] = 8'(-$signed(8'(8'(-r) >> 1)));
         end else begin
            rom[i] = 8'(r >>> 1);
         end
      end
      return rom;
   endfunction

   localparam rom_type NOISE_ROM = build_noise();

   typedef struct packed {
      logic [34:0] main_osc;
      logic [34:0] pitch_osc;
      logic [34:0] volume_osc;
      logic [55:0] envelope;
   } cfg_type;

   typedef struct packed {
      logic       load_restart;
      logic       div_start;
      logic [2:0] div_sel;
      logic       env_calc;
      logic       mul1;
      logic       mul2;
      logic       finish;
      logic       silence;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic active;
      logic out_full;
   } sts_type;

   function automatic logic signed [7:0] wave_value(logic [2:0] model, logic [7:0] idx);
      logic [6:0] half;
      logic [6:0] q;
      logic signed [8:0] s;
      logic signed [8:0] w;
      half = idx[6:0];
      q = (half <= 7'd64) ? half : 7'(8'd128 - {1'b0, half});
      s = $signed({3'b0, QSINE[q]});
      case (model)
         MODEL_SINE:   w = idx[7] ? -s : s;
         MODEL_TRI: begin
            if (idx < 8'd64) w = $signed({1'b0, idx});
            else if (idx < 8'd192) w = 9'sd128 - $signed({1'b0, idx});
            else w = $signed({1'b0, idx}) - 9'sd256;
         end
         MODEL_SAWUP:  w = $signed({2'b0, idx[7:1]}) - 9'sd64;
         MODEL_SAWDN:  w = 9'sd64 - $signed({2'b0, idx[7:1]});
         MODEL_SQUARE: w = idx[7] ? -9'sd64 : 9'sd64;
         MODEL_NOISE:  w = 9'($signed(NOISE_ROM[idx]));
         default:      w = 9'sd0;
      endcase
      return w[7:0];
   endfunction

   // Signed division by 64, truncating toward zero.
   function automatic logic signed [31:0] trunc64(logic signed [31:0] x);
      logic signed [31:0] b;
      b = (x < 0) ? x + 32'sd63 : x;
      return b >>> 6;
   endfunction

endpackage

// ===== sv/wts_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wts_div #(
   parameter int DVW = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [DVW-1:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient
);
   import wts_pkg::*;

   logic [DVW-1:0] rem_ff, rem_in;
   logic [31:0]    quo_ff, quo_in;
   logic [DVW-1:0] div_ff, div_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DVW:0]   trial;
   logic           fits;

   assign trial = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DVW'(trial - {1'b0, div_ff}) : trial[DVW-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/wts_datapath.sv =====
// Datapath: oscillator state, envelope, products, divider and output register.
`timescale 1ns / 1ps
module wts_datapath #(
   parameter int INDEX_BITS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wts_pkg::cfg_type      cfg,
   input  logic [INDEX_BITS-1:0] sample_count,
   input  wts_pkg::cmd_type      cmd,
   output wts_pkg::sts_type      sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);
   import wts_pkg::*;

   localparam int DVW = (INDEX_BITS > 9) ? INDEX_BITS : 9;

   logic [23:0] main_phase_ff, main_phase_in, pitch_phase_ff, volume_phase_ff;
   logic [23:0] main_step_ff, pitch_step_ff, volume_step_ff;
   logic [INDEX_BITS-1:0] idx_ff;
   logic [2:0]  sel_ff;
   logic [7:0]  d_ff;
   logic signed [7:0] env_ff;
   logic [16:0] lvl_ff;
   logic [8:0]  len_ff;
   logic        len_ok_ff;
   logic signed [10:0] m1_ff, vf_ff;
   logic signed [15:0] v2_ff;
   logic [31:0] p1_ff;
   logic        neg_ff;
   logic [39:0] p2_ff;
   logic        out_valid_ff;
   logic [7:0]  out_sample_ff;
   logic        out_last_ff;

   logic [31:0]    div_dividend;
   logic [DVW-1:0] div_divisor;
   logic           div_busy, div_done;
   logic [31:0]    quotient;
   logic           count_zero;

   assign count_zero = (sample_count == '0);

   always_comb begin
      case (cmd.div_sel)
         SEL_MAIN:  div_dividend = {cfg.main_osc[26:11], 16'b0};
         SEL_PITCH: div_dividend = {cfg.pitch_osc[26:11], 16'b0};
         SEL_VOL:   div_dividend = {cfg.volume_osc[26:11], 16'b0};
         SEL_D:     div_dividend = 32'({idx_ff, 8'b0});
         SEL_ENV:   div_dividend = 32'(lvl_ff);
         default:   div_dividend = '0;
      endcase
      div_divisor = (cmd.div_sel == SEL_ENV) ? DVW'(len_ff) : DVW'(sample_count);
   end

   wts_div #(.DVW(DVW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // Envelope segment select and level numerator.
   logic [7:0] e_ini, e_ax, e_ay, e_bx, e_by, e_cx, e_cy, mab, tail_start;
   logic signed [10:0] y0, y1, seg_start, seg_len;
   logic signed [21:0] lvl_raw;
   assign {e_cy, e_cx, e_by, e_bx, e_ay, e_ax, e_ini} = cfg.envelope;
   assign mab        = (e_ax > e_bx) ? e_ax : e_bx;
   assign tail_start = (mab > e_cx) ? mab : e_cx;

   always_comb begin
      if (d_ff < e_ax) begin
         y0 = 11'(e_ini); y1 = 11'(e_ay); seg_start = '0; seg_len = 11'(e_ax);
      end else if (d_ff < e_bx) begin
         y0 = 11'(e_ay); y1 = 11'(e_by); seg_start = 11'(e_ax);
         seg_len = 11'(e_bx) - 11'(e_ax);
      end else if (d_ff < e_cx) begin
         y0 = 11'(e_by); y1 = 11'(e_cy); seg_start = 11'(mab);
         seg_len = 11'(e_cx) - 11'(e_bx);
      end else begin
         y0 = 11'(e_cy); y1 = '0; seg_start = 11'(tail_start);
         seg_len = 11'sd256 - 11'(e_cx);
      end
      lvl_raw = 22'(y0 * seg_len) + 22'((11'(d_ff) - seg_start) * (y1 - y0));
   end

   // Wave lookups, products and the pitch-bent main phase.
   logic signed [7:0] wm, wv, wp;
   logic signed [16:0] pm, pv;
   logic [7:0] wp_mag;
   logic signed [31:0] m1_full, vf_full, v2_full, v3_full;
   logic [23:0] bend_add, bend_sub;

   assign wm = wave_value(cfg.main_osc[2:0], main_phase_ff[23:16]);
   assign wv = wave_value(cfg.volume_osc[2:0], volume_phase_ff[23:16]);
   assign wp = wave_value(cfg.pitch_osc[2:0], pitch_phase_ff[23:16]);
   assign pm = wm * $signed({1'b0, cfg.main_osc[10:3]});
   assign pv = wv * $signed({1'b0, cfg.volume_osc[10:3]});
   assign wp_mag = wp[7] ? 8'(-wp) : 8'(wp);
   assign m1_full = trunc64(32'(pm));
   assign vf_full = trunc64(32'(pv)) + 32'sd64;
   assign v2_full = trunc64(32'(m1_ff * vf_ff));
   assign v3_full = trunc64(32'(v2_ff * env_ff));
   assign bend_add = main_phase_ff + main_step_ff + p2_ff[34:11];
   assign bend_sub = main_phase_ff + main_step_ff - p2_ff[36:13];
   assign main_phase_in = neg_ff ? bend_sub : bend_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_phase_ff   <= '0;
         pitch_phase_ff  <= '0;
         volume_phase_ff <= '0;
         main_step_ff    <= '0;
         pitch_step_ff   <= '0;
         volume_step_ff  <= '0;
         idx_ff          <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (cmd.load_restart) begin
            idx_ff          <= '0;
            main_phase_ff   <= {cfg.main_osc[34:27], 16'b0};
            pitch_phase_ff  <= {cfg.pitch_osc[34:27], 16'b0};
            volume_phase_ff <= {cfg.volume_osc[34:27], 16'b0};
         end
         if (div_done) begin
            case (sel_ff)
               SEL_MAIN:  main_step_ff   <= count_zero ? '0 : quotient[23:0];
               SEL_PITCH: pitch_step_ff  <= count_zero ? '0 : quotient[23:0];
               SEL_VOL:   volume_step_ff <= count_zero ? '0 : quotient[23:0];
               default: ;
            endcase
         end
         if (cmd.finish) begin
            main_phase_ff   <= main_phase_in;
            pitch_phase_ff  <= pitch_phase_ff + pitch_step_ff;
            volume_phase_ff <= volume_phase_ff + volume_step_ff;
            idx_ff          <= idx_ff + 1'b1;
         end
         if (cmd.finish || cmd.silence) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) sel_ff <= cmd.div_sel;
      if (div_done && sel_ff == SEL_D) d_ff <= quotient[7:0];
      if (div_done && sel_ff == SEL_ENV) env_ff <= len_ok_ff ? $signed(quotient[7:0]) : 8'sd0;
      if (cmd.env_calc) begin
         lvl_ff    <= lvl_raw[21] ? '0 : lvl_raw[16:0];
         len_ff    <= seg_len[8:0];
         len_ok_ff <= (seg_len > 11'sd0);
      end
      if (cmd.mul1) begin
         m1_ff  <= m1_full[10:0];
         vf_ff  <= vf_full[10:0];
         p1_ff  <= 32'(main_step_ff * wp_mag);
         neg_ff <= wp[7];
      end
      if (cmd.mul2) begin
         v2_ff <= v2_full[15:0];
         p2_ff <= 40'(p1_ff * cfg.pitch_osc[10:3]);
      end
      if (cmd.finish) begin
         out_sample_ff <= v3_full[7:0] ^ 8'h80;
         out_last_ff   <= ({1'b0, idx_ff} + 1'b1) == {1'b0, sample_count};
      end else if (cmd.silence) begin
         out_sample_ff <= 8'h80;
         out_last_ff   <= 1'b0;
      end
   end

   assign sts.div_busy = div_busy;
   assign sts.div_done = div_done;
   assign sts.active   = idx_ff < sample_count;
   assign sts.out_full = out_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/wts_ctrl.sv =====
// Controller state machine sequencing restart, divisions and products per word.
`timescale 1ns / 1ps
module wts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             restart,
   output logic             req_tready,
   input  wts_pkg::sts_type sts,
   output wts_pkg::cmd_type cmd
);
   import wts_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_DMAIN  = 4'd2;
   localparam logic [3:0] ST_DPITCH = 4'd3;
   localparam logic [3:0] ST_DVOL   = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_DIVD   = 4'd6;
   localparam logic [3:0] ST_ENV    = 4'd7;
   localparam logic [3:0] ST_DIVE   = 4'd8;
   localparam logic [3:0] ST_MUL1   = 4'd9;
   localparam logic [3:0] ST_MUL2   = 4'd10;
   localparam logic [3:0] ST_MUL3   = 4'd11;
   localparam logic [3:0] ST_SILENT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       div_go;

   assign div_go = !sts.div_busy && !sts.div_done;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = restart ? ST_LOAD : ST_CHECK;
         end
         ST_LOAD: begin
            cmd.load_restart = 1'b1;
            state_in = ST_DMAIN;
         end
         ST_DMAIN: begin
            cmd.div_sel = SEL_MAIN;
            cmd.div_start = div_go;
            if (sts.div_done) state_in = ST_DPITCH;
         end
         ST_DPITCH: begin
            cmd.div_sel = SEL_PITCH;
            cmd.div_start = div_go;
            if (sts.div_done) state_in = ST_DVOL;
         end
         ST_DVOL: begin
            cmd.div_sel = SEL_VOL;
            cmd.div_start = div_go;
            if (sts.div_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.active ? ST_DIVD : ST_SILENT;
         end
         ST_DIVD: begin
            cmd.div_sel = SEL_D;
            cmd.div_start = div_go;
            if (sts.div_done) state_in = ST_ENV;
         end
         ST_ENV: begin
            cmd.env_calc = 1'b1;
            state_in = ST_DIVE;
         end
         ST_DIVE: begin
            cmd.div_sel = SEL_ENV;
            cmd.div_start = div_go;
            if (sts.div_done) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SILENT: begin
            if (!sts.out_full) begin
               cmd.silence = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sts.div_busy)
      else $error("divider busy while idle");
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.silence) |=> sts.out_full)
      else $error("output word not held");
`endif

endmodule

// ===== sv/wavetable_tone_synthesizer_core.sv =====
// Top level of the wavetable tone synthesizer: register file, controller and datapath.
`timescale 1ns / 1ps
// Usage:
//  - req channel: one word per sample tick; req_tdata[0] = restart. A restart
//    reloads phases from the offsets and recomputes the three phase steps.
//  - rsp channel: one word per request; rsp_tdata = 8-bit unsigned sample
//    (128 is silence), rsp_tlast marks the final sample of the sound.
//  - csr port: APB-style, 64-bit data, register i at byte address 8*i:
//    sample_count, main_osc, pitch_osc, volume_osc, envelope_shape.
//    Write only while no request is in flight.
// Sequencing:
//  - a plain tick runs two divisions on the shared divider (sample position,
//    envelope level), the check and envelope setup states and three product
//    stages before its response word is valid. A restart adds a load state and
//    three step divisions.
//  - once the sound is finished a tick skips the divisions and returns 128.
//  - one request is processed at a time; the next is accepted as soon as the
//    controller is idle, even while the previous response is still held.
// Reset: clears phases, steps and sample index; sample_count resets to 1.
// Stall: a held response blocks only the final stage of the next request.
module wavetable_tone_synthesizer_core #(
   parameter int INDEX_BITS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] sample
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import wts_pkg::*;

   logic [INDEX_BITS-1:0] sample_count_ff;
   cfg_type               cfg_ff;
   cmd_type               cmd;
   sts_type               sts;
   logic                  csr_write;
   logic [2:0]            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   // Register file: take writes at the access phase, ignore unmapped slots.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= INDEX_BITS'(1);
         cfg_ff          <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_SAMPLE_COUNT: sample_count_ff   <= csr_pwdata[INDEX_BITS-1:0];
            REG_MAIN_OSC:     cfg_ff.main_osc   <= csr_pwdata[34:0];
            REG_PITCH_OSC:    cfg_ff.pitch_osc  <= csr_pwdata[34:0];
            REG_VOLUME_OSC:   cfg_ff.volume_osc <= csr_pwdata[34:0];
            REG_ENVELOPE:     cfg_ff.envelope   <= csr_pwdata[55:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero for unmapped slots.
   always_comb begin
      case (csr_index)
         REG_SAMPLE_COUNT: csr_prdata = 64'(sample_count_ff);
         REG_MAIN_OSC:     csr_prdata = 64'(cfg_ff.main_osc);
         REG_PITCH_OSC:    csr_prdata = 64'(cfg_ff.pitch_osc);
         REG_VOLUME_OSC:   csr_prdata = 64'(cfg_ff.volume_osc);
         REG_ENVELOPE:     csr_prdata = 64'(cfg_ff.envelope);
         default:          csr_prdata = '0;
      endcase
   end

   // Sequence each request word through restart, divisions and products.
   wts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .restart    (req_tdata[0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold oscillator state and produce the response word.
   wts_datapath #(.INDEX_BITS(INDEX_BITS)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .sample_count (sample_count_ff),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
